@@ src/bws_pkg.sv @@
`timescale 1ns / 1ps
package bws_pkg;

    localparam int TEXT_DEPTH    = 1024;
    localparam int PATTERN_DEPTH = 64;

    localparam int TXT_AW = (TEXT_DEPTH > 1) ? $clog2(TEXT_DEPTH) : 1;
    localparam int TXT_CW = $clog2(TEXT_DEPTH + 1);
    localparam int PAT_AW = (PATTERN_DEPTH > 1) ? $clog2(PATTERN_DEPTH) : 1;
    localparam int PAT_CW = $clog2(PATTERN_DEPTH + 1);

    localparam int CMD_W   = 2;
    localparam int SYM_W   = 8;
    localparam int BM_W    = 7;
    localparam int PL_W    = 7;
    localparam int SCORE_W = 17;
    localparam int FRAC_W  = 16;

    // dividend of the score division is best_matches followed by the fraction bits
    localparam int DVD_W  = PAT_CW + FRAC_W;
    localparam int DBIT_W = $clog2(DVD_W);

    localparam int FIFO_DEPTH = 2;
    localparam int FIFO_AW    = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    localparam logic [CMD_W-1:0] CMD_TEXT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_PAT  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_RUN  = 2'd2;

    typedef enum logic [1:0] {
        OP_TEXT,
        OP_PAT,
        OP_RUN
    } t_op;

    typedef struct packed {
        t_op              op;
        logic [SYM_W-1:0] sym;
    } t_item;

    typedef struct packed {
        logic  vld;
        t_item item;
    } t_push;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_DIV,
        ST_FIN
    } t_state;

endpackage

@@ src/best_window_similarity_search.sv @@
`timescale 1ns / 1ps
// Best-window similarity search.
// Input channel (i_in_valid / o_in_ready) carries one word per command:
// i_command 0 appends i_symbol to the text, 1 appends it to the pattern,
// 2 runs the search; code 3 is accepted and dropped.
// Loads are taken one word per cycle while the queue has room; a two-entry
// queue parts the front decoder from the engine, so the input keeps
// flowing while the engine works on a load or holds a finished result.
// A run slides the pattern over every fitting offset, one symbol compare
// per cycle through the single read port of each store, then divides
// best/length one quotient bit per cycle. When the pattern is empty or
// longer than the text, the run skips the scan and the division. The
// next word waits in the queue during the run.
// The result sits in an output register (o_out_valid / i_out_ready) until
// taken; loads still proceed while it waits, a following run holds.
// The run empties both stores and clears the overflow flag.
// Reset (i_rst_n low, synchronous) empties the stores and the queue and
// drops any pending result; no clearing pass is needed.
module best_window_similarity_search import bws_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [CMD_W-1:0]   i_command,
    input  logic [SYM_W-1:0]   i_symbol,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [BM_W-1:0]    o_best_matches,
    output logic [PL_W-1:0]    o_pattern_length,
    output logic [SCORE_W-1:0] o_score_q16,
    output logic               o_overflow
);

    t_push w_push;
    t_item w_head;
    logic  w_full;
    logic  w_empty;
    logic  w_pop;

    // decode and drop unused codes
    bws_front u_front (
        .i_in_valid  (i_in_valid),
        .i_command   (i_command),
        .i_symbol    (i_symbol),
        .i_fifo_full (w_full),
        .o_in_ready  (o_in_ready),
        .o_push      (w_push)
    );

    // hold decoded words while the engine is busy
    bws_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_empty (w_empty),
        .o_head  (w_head)
    );

    // stores, window scan, divider and result register
    bws_engine u_engine (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_fifo_empty     (w_empty),
        .i_head           (w_head),
        .o_pop            (w_pop),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_best_matches   (o_best_matches),
        .o_pattern_length (o_pattern_length),
        .o_score_q16      (o_score_q16),
        .o_overflow       (o_overflow)
    );

endmodule

@@ src/bws_front.sv @@
`timescale 1ns / 1ps
module bws_front import bws_pkg::*; (
    input  logic             i_in_valid,
    input  logic [CMD_W-1:0] i_command,
    input  logic [SYM_W-1:0] i_symbol,
    input  logic             i_fifo_full,
    output logic             o_in_ready,
    output t_push            o_push
);

    logic w_keep;
    t_op  w_op;

    assign o_in_ready = !i_fifo_full;

    // classify the command; the unused code is accepted and dropped
    always_comb begin
        w_keep = 1'b1;
        w_op   = OP_TEXT;
        unique case (i_command)
            CMD_TEXT: w_op = OP_TEXT;
            CMD_PAT:  w_op = OP_PAT;
            CMD_RUN:  w_op = OP_RUN;
            default:  w_keep = 1'b0;
        endcase
    end

    always_comb begin
        o_push.vld      = i_in_valid && o_in_ready && w_keep;
        o_push.item.op  = w_op;
        o_push.item.sym = i_symbol;
    end

endmodule

@@ src/bws_fifo.sv @@
`timescale 1ns / 1ps
module bws_fifo import bws_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_push i_push,
    input  logic  i_pop,
    output logic  o_full,
    output logic  o_empty,
    output t_item o_head
);

    t_item               r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0]  r_wr;
    logic [FIFO_AW-1:0]  r_rd;
    logic [FIFO_CW-1:0]  r_cnt;
    logic                w_push;
    logic                w_pop;

    assign o_full  = (r_cnt == FIFO_CW'(FIFO_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_mem[r_rd];
    assign w_push  = i_push.vld && !o_full;
    assign w_pop   = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_push.item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wr <= (r_wr == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (w_pop) begin
                r_rd <= (r_rd == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

@@ src/bws_engine.sv @@
`timescale 1ns / 1ps
module bws_engine import bws_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_fifo_empty,
    input  t_item              i_head,
    output logic               o_pop,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [BM_W-1:0]    o_best_matches,
    output logic [PL_W-1:0]    o_pattern_length,
    output logic [SCORE_W-1:0] o_score_q16,
    output logic               o_overflow
);

    t_state r_state, n_state;

    logic [SYM_W-1:0]  r_txt_mem [TEXT_DEPTH];
    logic [SYM_W-1:0]  r_pat_mem [PATTERN_DEPTH];
    logic [SYM_W-1:0]  r_txt_q;
    logic [SYM_W-1:0]  r_pat_q;

    logic [TXT_CW-1:0] r_tcnt;
    logic [PAT_CW-1:0] r_pcnt;
    logic              r_ovf;

    logic [PAT_CW-1:0] r_plen;
    logic [PAT_AW-1:0] r_plen_m1;
    logic [TXT_AW-1:0] r_off_last;
    logic              r_ovf_s;
    logic [TXT_AW-1:0] r_off;
    logic [PAT_AW-1:0] r_k;
    logic              r_rd_vld;
    logic              r_rd_last;
    logic [PAT_CW-1:0] r_hits;
    logic [PAT_CW-1:0] r_best;
    logic [PAT_CW-1:0] r_rem;
    logic [SCORE_W-1:0] r_quo;
    logic [DBIT_W-1:0] r_bit;

    logic               r_out_vld;
    logic [BM_W-1:0]    r_out_best;
    logic [PL_W-1:0]    r_out_plen;
    logic [SCORE_W-1:0] r_out_score;
    logic               r_out_ovf;

    logic c_pop, c_issue, c_div, c_fin;
    logic w_run, w_none, w_last_issue;
    logic w_txt_we, w_pat_we;
    logic [TXT_AW-1:0] w_txt_ra;
    logic [PAT_CW-1:0] w_hits_n;
    logic [DVD_W-1:0]  w_dvd;
    logic [PAT_CW:0]   w_trial;
    logic              w_ge;

    assign w_run  = (i_head.op == OP_RUN);
    assign w_none = (r_pcnt == '0) || (32'(r_pcnt) > 32'(r_tcnt));
    assign w_last_issue = (r_k == r_plen_m1) && (r_off == r_off_last);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:  if (c_pop && w_run) n_state = w_none ? ST_FIN : ST_SCAN;
            ST_SCAN:  if (w_last_issue) n_state = ST_DRAIN;
            ST_DRAIN: n_state = ST_DIV;
            ST_DIV:   if (r_bit == '0) n_state = ST_FIN;
            ST_FIN:   n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // state outputs; a run waits until the previous result is taken
    always_comb begin
        c_pop   = 1'b0;
        c_issue = 1'b0;
        c_div   = 1'b0;
        c_fin   = 1'b0;
        unique case (r_state)
            ST_IDLE:  c_pop   = !i_fifo_empty && (!w_run || !r_out_vld);
            ST_SCAN:  c_issue = 1'b1;
            ST_DRAIN: ;
            ST_DIV:   c_div   = 1'b1;
            ST_FIN:   c_fin   = 1'b1;
            default:  ;
        endcase
    end

    assign o_pop    = c_pop;
    assign w_txt_we = c_pop && (i_head.op == OP_TEXT) && (r_tcnt < TXT_CW'(TEXT_DEPTH));
    assign w_pat_we = c_pop && (i_head.op == OP_PAT) && (r_pcnt < PAT_CW'(PATTERN_DEPTH));
    assign w_txt_ra = TXT_AW'(32'(r_off) + 32'(r_k));

    always_ff @(posedge i_clk) begin
        if (w_txt_we) begin
            r_txt_mem[r_tcnt[TXT_AW-1:0]] <= i_head.sym;
        end
        r_txt_q <= r_txt_mem[w_txt_ra];
    end

    always_ff @(posedge i_clk) begin
        if (w_pat_we) begin
            r_pat_mem[r_pcnt[PAT_AW-1:0]] <= i_head.sym;
        end
        r_pat_q <= r_pat_mem[r_k];
    end

    assign w_hits_n = r_hits + PAT_CW'(r_txt_q == r_pat_q);

    // restoring division, one quotient bit per cycle
    assign w_dvd   = {r_best, {FRAC_W{1'b0}}};
    assign w_trial = {r_rem, w_dvd[r_bit]};
    assign w_ge    = (w_trial >= {1'b0, r_plen});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_tcnt    <= '0;
            r_pcnt    <= '0;
            r_ovf     <= 1'b0;
            r_rd_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_rd_vld <= c_issue;
            if (c_pop) begin
                unique case (i_head.op)
                    OP_TEXT: begin
                        if (w_txt_we) r_tcnt <= r_tcnt + 1'b1;
                        else          r_ovf  <= 1'b1;
                    end
                    OP_PAT: begin
                        if (w_pat_we) r_pcnt <= r_pcnt + 1'b1;
                        else          r_ovf  <= 1'b1;
                    end
                    OP_RUN: begin
                        r_tcnt <= '0;
                        r_pcnt <= '0;
                        r_ovf  <= 1'b0;
                    end
                    default: ;
                endcase
            end
            if (r_out_vld && i_out_ready) begin
                r_out_vld <= 1'b0;
            end
            if (c_fin) begin
                r_out_vld <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (c_pop && w_run) begin
            r_plen     <= r_pcnt;
            r_plen_m1  <= PAT_AW'(r_pcnt - 1'b1);
            r_off_last <= TXT_AW'(32'(r_tcnt) - 32'(r_pcnt));
            r_ovf_s    <= r_ovf;
            r_off      <= '0;
            r_k        <= '0;
            r_hits     <= '0;
            r_best     <= '0;
            r_rem      <= '0;
            r_quo      <= '0;
            r_bit      <= DBIT_W'(DVD_W - 1);
        end
        if (c_issue) begin
            if (r_k == r_plen_m1) begin
                r_k   <= '0;
                r_off <= r_off + 1'b1;
            end else begin
                r_k <= r_k + 1'b1;
            end
        end
        if (r_rd_vld) begin
            if (r_rd_last) begin
                r_hits <= '0;
                if (w_hits_n > r_best) r_best <= w_hits_n;
            end else begin
                r_hits <= w_hits_n;
            end
        end
        r_rd_last <= (r_k == r_plen_m1);
        if (c_div) begin
            r_rem <= w_ge ? PAT_CW'(w_trial - {1'b0, r_plen}) : PAT_CW'(w_trial);
            r_quo <= {r_quo[SCORE_W-2:0], w_ge};
            r_bit <= r_bit - 1'b1;
        end
        if (c_fin) begin
            r_out_best  <= BM_W'(r_best);
            r_out_plen  <= PL_W'(r_plen);
            r_out_score <= r_quo;
            r_out_ovf   <= r_ovf_s;
        end
    end

    assign o_out_valid      = r_out_vld;
    assign o_best_matches   = r_out_best;
    assign o_pattern_length = r_out_plen;
    assign o_score_q16      = r_out_score;
    assign o_overflow       = r_out_ovf;

endmodule

@@ src/bws_checker.sv @@
`timescale 1ns / 1ps
module bws_checker import bws_pkg::*; (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input logic [BM_W-1:0]    o_best_matches,
    input logic [PL_W-1:0]    o_pattern_length,
    input logic [SCORE_W-1:0] o_score_q16,
    input logic               o_overflow
);

    // reset drops any pending result
    a_reset_clears: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_best_matches)
            && $stable(o_pattern_length) && $stable(o_score_q16) && $stable(o_overflow))
        else $error("stalled result changed");

    a_best_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_best_matches <= o_pattern_length
            && o_score_q16 <= SCORE_W'(1 << FRAC_W))
        else $error("best count or score out of range");

    a_empty_pattern: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_pattern_length == '0 |-> o_best_matches == '0 && o_score_q16 == '0)
        else $error("empty pattern gave a nonzero score");

endmodule

bind best_window_similarity_search bws_checker u_bws_checker (.*);

@@ test/best_window_similarity_search_tb.sv @@
`timescale 1ns / 1ps
module best_window_similarity_search_tb;
    import bws_pkg::*;

    // Code 3 has no meaning: the block takes the word and drops it.
    localparam logic [CMD_W-1:0] CMD_NOP = 2'd3;

    // The slowest legal run is far below this, even a full text store
    // against a full pattern store.
    localparam longint TIMEOUT_NS    = 64'd20_000_000;
    localparam int     SETTLE_CYCLES = 64;

    typedef enum int {
        TEXT_FIRST,
        PATTERN_FIRST,
        INTERLEAVED
    } t_load_order;

    typedef struct {
        logic [BM_W-1:0]    best;
        logic [PL_W-1:0]    plen;
        logic [SCORE_W-1:0] score;
        logic               ovf;
    } t_search_result;

    logic               i_clk;
    logic               i_rst_n     = 1'b0;
    logic               i_in_valid  = 1'b0;
    logic [CMD_W-1:0]   i_command   = '0;
    logic [SYM_W-1:0]   i_symbol    = '0;
    logic               i_out_ready = 1'b0;
    logic               o_in_ready;
    logic               o_out_valid;
    logic [BM_W-1:0]    o_best_matches;
    logic [PL_W-1:0]    o_pattern_length;
    logic [SCORE_W-1:0] o_score_q16;
    logic               o_overflow;

    // Shadow copy of the block: both stores, the drop flag, and the
    // results still owed by the block in arrival order.
    logic [SYM_W-1:0] text_shadow[$];
    logic [SYM_W-1:0] pattern_shadow[$];
    logic             dropped_shadow = 1'b0;
    t_search_result   pending_scores[$];

    int mismatch_count = 0;
    int words_sent     = 0;
    int send_gap_pct   = 0;
    int recv_stall_pct = 0;

    best_window_similarity_search dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_command        (i_command),
        .i_symbol         (i_symbol),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_best_matches   (o_best_matches),
        .o_pattern_length (o_pattern_length),
        .o_score_q16      (o_score_q16),
        .o_overflow       (o_overflow)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("Mismatches found");
        $finish;
    end

    // Largest number of equal symbols over every offset where the whole
    // pattern fits inside the text; zero when no offset exists.
    function automatic int best_window_hits();
        int best;
        int hits;
        best = 0;
        if (pattern_shadow.size() == 0 || pattern_shadow.size() > text_shadow.size())
            return 0;
        for (int off = 0; off + pattern_shadow.size() <= text_shadow.size(); off++) begin
            hits = 0;
            for (int k = 0; k < pattern_shadow.size(); k++)
                if (text_shadow[off + k] == pattern_shadow[k])
                    hits++;
            if (hits > best)
                best = hits;
        end
        return best;
    endfunction

    // Advance the shadow state by one accepted word; a run queues the
    // result the block owes and empties everything.
    function automatic void track_word(logic [CMD_W-1:0] cmd, logic [SYM_W-1:0] sym);
        t_search_result res;
        int             best;
        int             plen;
        case (cmd)
            CMD_TEXT: begin
                if (text_shadow.size() < TEXT_DEPTH)
                    text_shadow.push_back(sym);
                else
                    dropped_shadow = 1'b1;
            end
            CMD_PAT: begin
                if (pattern_shadow.size() < PATTERN_DEPTH)
                    pattern_shadow.push_back(sym);
                else
                    dropped_shadow = 1'b1;
            end
            CMD_RUN: begin
                best      = best_window_hits();
                plen      = pattern_shadow.size();
                res.best  = BM_W'(best);
                res.plen  = PL_W'(plen);
                res.score = '0;
                // truncating divide: best/plen with 16 fraction bits
                if (plen != 0 && plen <= text_shadow.size())
                    res.score = SCORE_W'((best << FRAC_W) / plen);
                res.ovf = dropped_shadow;
                pending_scores.push_back(res);
                text_shadow.delete();
                pattern_shadow.delete();
                dropped_shadow = 1'b0;
            end
            default: ;
        endcase
    endfunction

    // Offer one word. Idle cycles come first, with junk on the payload;
    // once valid rises it holds with a steady payload until taken.
    // Handshakes are sampled at the falling edge, where every signal
    // has settled for the coming rising edge.
    task automatic send_word(input logic [CMD_W-1:0] cmd, input logic [SYM_W-1:0] sym);
        bit taken;
        while ($urandom_range(99) < send_gap_pct) begin
            i_in_valid <= 1'b0;
            i_command  <= CMD_W'($urandom);
            i_symbol   <= SYM_W'($urandom);
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_command  <= cmd;
        i_symbol   <= sym;
        do begin
            @(negedge i_clk);
            taken = o_in_ready;
            @(posedge i_clk);
        end while (!taken);
        track_word(cmd, sym);
        if (cmd != CMD_NOP)
            words_sent++;
    endtask

    // Load both stores in the given order, then run the search.
    task automatic send_search(input logic [SYM_W-1:0] txt[$], input logic [SYM_W-1:0] pat[$],
                               input t_load_order order, input bit with_nops);
        int ti;
        int pi;
        bit take_text;
        ti = 0;
        pi = 0;
        while (ti < txt.size() || pi < pat.size()) begin
            case (order)
                TEXT_FIRST:    take_text = ti < txt.size();
                PATTERN_FIRST: take_text = pi >= pat.size();
                default:       take_text = (pi >= pat.size()) ||
                                           (ti < txt.size() && $urandom_range(1) == 1);
            endcase
            if (take_text) begin
                send_word(CMD_TEXT, txt[ti]);
                ti++;
            end else begin
                send_word(CMD_PAT, pat[pi]);
                pi++;
            end
            if (with_nops && $urandom_range(19) == 0)
                send_word(CMD_NOP, SYM_W'($urandom));
        end
        send_word(CMD_RUN, SYM_W'($urandom));
    endtask

    // Hold the input and wait for every owed result. The extra edge keeps
    // the lowered valid apart from the next rise.
    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (pending_scores.size() != 0)
            @(posedge i_clk);
        @(posedge i_clk);
    endtask

    task automatic test_edge_cases();
        logic [SYM_W-1:0] txt[$];
        logic [SYM_W-1:0] pat[$];
        // run with both stores empty
        send_word(CMD_RUN, 8'hFF);
        // unused code with both extreme symbols: no result, no state change
        send_word(CMD_NOP, 8'hFF);
        send_word(CMD_NOP, 8'h00);
        // single symbol, exact hit: score is exactly one
        txt = '{8'hFF};
        pat = '{8'hFF};
        send_search(txt, pat, TEXT_FIRST, 1'b0);
        // pattern longer than the text: no offset at all
        txt = '{8'h00};
        pat = '{8'h00, 8'h55};
        send_search(txt, pat, PATTERN_FIRST, 1'b0);
        // empty pattern over a loaded text
        txt = '{8'hA5, 8'h5A, 8'h00};
        pat.delete();
        send_search(txt, pat, TEXT_FIRST, 1'b0);
        // two of three at the middle offset: fraction truncates
        txt = '{8'h00, 8'hFF, 8'hA5, 8'h5A, 8'hFF};
        pat = '{8'hFF, 8'hA5, 8'h00};
        send_search(txt, pat, INTERLEAVED, 1'b0);
    endtask

    task automatic test_store_full();
        logic [SYM_W-1:0] txt[$];
        logic [SYM_W-1:0] pat[$];
        int               flip;
        // Full pattern store, text overrun by two. The pattern copy sits in
        // the last window the text store can hold, so the best window is
        // also the last offset scanned.
        for (int i = 0; i < PATTERN_DEPTH; i++)
            pat.push_back(SYM_W'($urandom));
        for (int i = 0; i < TEXT_DEPTH + 2; i++)
            txt.push_back(SYM_W'($urandom));
        for (int i = 0; i < PATTERN_DEPTH; i++)
            txt[TEXT_DEPTH - PATTERN_DEPTH + i] = pat[i];
        send_search(txt, pat, PATTERN_FIRST, 1'b0);

        // Pattern overrun by two; the text matches the kept part but for one symbol.
        txt.delete();
        for (int i = 0; i < PATTERN_DEPTH; i++)
            txt.push_back(pat[i]);
        flip      = $urandom_range(PATTERN_DEPTH - 1);
        txt[flip] = ~txt[flip];
        pat.push_back(SYM_W'($urandom));
        pat.push_back(SYM_W'($urandom));
        send_search(txt, pat, INTERLEAVED, 1'b0);

        // the previous run must have cleared the drop flag
        send_word(CMD_RUN, SYM_W'($urandom));
    endtask

    function automatic logic [SYM_W-1:0] draw_symbol(logic [SYM_W-1:0] alphabet[4], int alpha_n);
        if (alpha_n == 0)
            return SYM_W'($urandom);
        return alphabet[$urandom_range(alpha_n - 1)];
    endfunction

    // One random search. Mostly well-formed loads followed by a run, usually
    // drawn from a small alphabet so that hits are common, often with the pattern
    // planted in the text. The rest is loose words of any code.
    task automatic run_random_search();
        logic [SYM_W-1:0] txt[$];
        logic [SYM_W-1:0] pat[$];
        logic [SYM_W-1:0] alphabet[4];
        int               alpha_n;
        int               t_len;
        int               p_len;
        int               sel;
        int               off;
        sel = $urandom_range(99);
        if (sel < 15) begin
            repeat ($urandom_range(8, 1))
                send_word(CMD_W'($urandom), SYM_W'($urandom));
            return;
        end
        if (sel < 17) begin
            // long text, short pattern: many offsets
            t_len = $urandom_range(300, 100);
            p_len = $urandom_range(4);
        end else if (sel < 20) begin
            // around a full pattern store, overruns included
            p_len = $urandom_range(PATTERN_DEPTH + 6, PATTERN_DEPTH - 4);
            t_len = $urandom_range(p_len + 24, p_len - 8);
        end else begin
            t_len = $urandom_range(40);
            p_len = $urandom_range(12);
        end
        case ($urandom_range(3))
            0:       alpha_n = 1;
            1:       alpha_n = 2;
            2:       alpha_n = 4;
            default: alpha_n = 0;
        endcase
        foreach (alphabet[i])
            alphabet[i] = SYM_W'($urandom);
        repeat (t_len)
            txt.push_back(draw_symbol(alphabet, alpha_n));
        repeat (p_len)
            pat.push_back(draw_symbol(alphabet, alpha_n));
        if (p_len != 0 && p_len <= t_len && $urandom_range(1) == 1) begin
            off = $urandom_range(t_len - p_len);
            for (int k = 0; k < p_len; k++)
                txt[off + k] = pat[k];
            repeat ($urandom_range(2))
                txt[off + $urandom_range(p_len - 1)] = SYM_W'($urandom);
        end
        send_search(txt, pat, t_load_order'($urandom_range(2)), $urandom_range(3) == 0);
    endtask

    task automatic test_random_searches(input int gap_pct, input int stall_pct, input int budget);
        int start;
        send_gap_pct   = gap_pct;
        recv_stall_pct = stall_pct;
        start          = words_sent;
        while (words_sent - start < budget)
            run_random_search();
        // pause the sender until the block has delivered everything
        drain_results();
    endtask

    // Result side: stall at random, at the rate of the current phase.
    always @(posedge i_clk)
        i_out_ready <= ($urandom_range(99) >= recv_stall_pct);

    task automatic check_field(input string name, input int unsigned want, input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatch_count++;
        end
    endtask

    // A word leaves the block at the next rising edge when valid and ready
    // are both high here; compare it against the oldest owed result.
    always @(negedge i_clk) begin : take_result
        t_search_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_scores.size() == 0) begin
                $error("result word with no run pending");
                mismatch_count++;
            end else begin
                want = pending_scores.pop_front();
                check_field("best_matches", want.best, o_best_matches);
                check_field("pattern_length", want.plen, o_pattern_length);
                check_field("score_q16", want.score, o_score_q16);
                check_field("overflow", want.ovf, o_overflow);
            end
        end
    end

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_edge_cases();
        drain_results();

        send_gap_pct   = 33;
        recv_stall_pct = 33;
        test_store_full();
        drain_results();

        test_random_searches(0, 0, 110);
        test_random_searches(83, 0, 110);
        test_random_searches(0, 83, 110);
        test_random_searches(33, 33, 110);

        // give a late stray word time to show up
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (pending_scores.size() != 0) begin
            $error("%0d results never arrived", pending_scores.size());
            mismatch_count++;
        end
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
